### rtl/assert_macros.svh
// Assertion macros for the checker file of the decoder.
// Depends on nothing; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is asserted.
`define X86D_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked while reset is asserted.
`define X86D_ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### rtl/x86d_pkg.sv
// Package for the byte-serial 16-bit x86 decoder: types, opcode patterns
// and decode functions. Used by every module of the block; depends on nothing.
package x86d_pkg;

    localparam logic [7:0] ACC_MASK  = 8'b1100_0110;
    localparam logic [7:0] ACC_MATCH = 8'b0000_0100;
    localparam logic [7:0] IRM_MASK  = 8'b1111_1100;
    localparam logic [7:0] IRM_MATCH = 8'b1000_0000;
    localparam logic [7:0] RMR_MASK  = 8'b1100_0100;
    localparam logic [7:0] RMR_MATCH = 8'b0000_0000;

    localparam logic [7:0] JCC_FIRST  = 8'h70;
    localparam logic [7:0] JCC_LAST   = 8'h7F;
    localparam logic [7:0] LOOP_FIRST = 8'hE0;
    localparam logic [7:0] LOOP_LAST  = 8'hE3;

    localparam logic [1:0] FORM_ACC  = 2'd0;
    localparam logic [1:0] FORM_IRM  = 2'd1;
    localparam logic [1:0] FORM_RMR  = 2'd2;
    localparam logic [1:0] FORM_JUMP = 2'd3;

    localparam logic [1:0] MOD_MEM    = 2'd0;
    localparam logic [1:0] MOD_DISP8  = 2'd1;
    localparam logic [1:0] MOD_DISP16 = 2'd2;
    localparam logic [2:0] RM_DIRECT  = 3'd6;

    localparam logic [1:0] LEN_NONE = 2'd0;
    localparam logic [1:0] LEN_BYTE = 2'd1;
    localparam logic [1:0] LEN_WORD = 2'd2;

    typedef enum logic [6:0] {
        PH_OPCODE  = 7'b000_0001,
        PH_MODRM   = 7'b000_0010,
        PH_DISP_LO = 7'b000_0100,
        PH_DISP_HI = 7'b000_1000,
        PH_IMM_LO  = 7'b001_0000,
        PH_IMM_HI  = 7'b010_0000,
        PH_OFFSET  = 7'b100_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]         form;
        logic [2:0]         alu_op;
        logic [7:0]         opcode;
        logic               wide;
        logic               reg_is_dest;
        logic [1:0]         mode;
        logic [2:0]         reg_field;
        logic [2:0]         rm_field;
        logic signed [15:0] displacement;
        logic signed [15:0] immediate;
        logic               bad_opcode;
    } record_t;

    typedef struct packed {
        logic    valid;
        record_t rec;
    } result_t;

    function automatic logic [1:0] form_of(input logic [7:0] op);
        logic [1:0] f;
        if ((op & ACC_MASK) == ACC_MATCH) f = FORM_ACC;
        else if ((op & IRM_MASK) == IRM_MATCH) f = FORM_IRM;
        else if ((op & RMR_MASK) == RMR_MATCH) f = FORM_RMR;
        else f = FORM_JUMP;
        return f;
    endfunction

    function automatic logic is_branch(input logic [7:0] op);
        return ((op >= JCC_FIRST) && (op <= JCC_LAST)) ||
               ((op >= LOOP_FIRST) && (op <= LOOP_LAST));
    endfunction

    function automatic logic [1:0] disp_len(input logic [7:0] modrm);
        logic [1:0] len;
        if (modrm[7:6] == MOD_DISP8) len = LEN_BYTE;
        else if (modrm[7:6] == MOD_DISP16) len = LEN_WORD;
        else if ((modrm[7:6] == MOD_MEM) && (modrm[2:0] == RM_DIRECT)) len = LEN_WORD;
        else len = LEN_NONE;
        return len;
    endfunction

    function automatic logic [1:0] imm_len(input logic [7:0] op);
        logic [1:0] f;
        logic [1:0] len;
        f = form_of(op);
        if (f == FORM_ACC) len = op[0] ? LEN_WORD : LEN_BYTE;
        else if (f == FORM_IRM) len = (op[0] && !op[1]) ? LEN_WORD : LEN_BYTE;
        else len = LEN_NONE;
        return len;
    endfunction

    function automatic logic [15:0] sext8(input logic [7:0] b);
        return {{8{b[7]}}, b};
    endfunction

    function automatic record_t build_record(input logic [7:0] op, input logic [7:0] m,
                                             input logic [15:0] disp,
                                             input logic [15:0] imm);
        record_t    r;
        logic [1:0] f;
        r = '0;
        f = form_of(op);
        r.form = f;
        r.opcode = op;
        r.displacement = disp;
        if (f == FORM_JUMP) begin
            r.bad_opcode = !is_branch(op);
        end
        else begin
            r.alu_op = (f == FORM_IRM) ? m[5:3] : op[5:3];
            r.wide = op[0];
            r.immediate = imm;
            if (f != FORM_ACC) begin
                r.mode = m[7:6];
                r.reg_field = m[5:3];
                r.rm_field = m[2:0];
            end
            if (f == FORM_RMR) begin
                r.reg_is_dest = op[1];
            end
        end
        return r;
    endfunction

endpackage

### rtl/x86_16bit_add_sub_cmp_jump_decoder.sv
// Top level of the byte-serial 16-bit x86 decoder for add/sub/cmp forms and
// short jumps. Depends on x86d_pkg, x86d_core and x86d_outreg.
//
// The slave channel takes one code byte per word. When the last byte of an
// instruction is taken, one decoded record goes out on the master channel;
// earlier bytes of the instruction produce nothing.
// Latency: the record is valid in the cycle after its last byte is taken.
// Throughput: one code byte per cycle while the receiver does not stall;
// the result register lets the next byte in as the waiting record is taken.
// A stalled receiver holds the record and its valid; the slave channel
// then stalls too, since s_axis_tready is low only while a record waits
// and m_axis_tready is low.
// Reset clears the phase to awaiting an opcode, clears the held bytes and
// accumulators and drops m_axis_tvalid. No clearing pass is needed.
// An unknown opcode takes one offset byte and returns a jump-form record
// with the error flag set in tuser.
module x86_16bit_add_sub_cmp_jump_decoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // code_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // form, alu_op, opcode, wide, reg_is_dest, mode, reg_field, rm_field,
    // displacement, immediate, zero pad
    output logic [55:0] m_axis_tdata,
    output logic        m_axis_tuser    // bad_opcode
);

    logic              take;
    x86d_pkg::result_t res;
    x86d_pkg::record_t rec;

    assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
    assign take = s_axis_tvalid && s_axis_tready;

    x86d_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .code_byte (s_axis_tdata),
        .res       (res)
    );

    x86d_outreg u_outreg (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .res   (res),
        .ready (m_axis_tready),
        .valid (m_axis_tvalid),
        .rec   (rec)
    );

    assign m_axis_tdata = {1'b0, rec.immediate, rec.displacement, rec.rm_field,
                           rec.reg_field, rec.mode, rec.reg_is_dest, rec.wide,
                           rec.opcode, rec.alu_op, rec.form};
    assign m_axis_tuser = rec.bad_opcode;

endmodule

### rtl/x86d_core.sv
// Instruction collector: phase register, held opcode, mod-reg-rm byte and
// displacement/immediate accumulators. Depends on x86d_pkg.
module x86d_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        code_byte,
    output x86d_pkg::result_t res
);

    x86d_pkg::phase_t phase_reg;
    x86d_pkg::phase_t phase_next;
    logic [7:0]       opcode_reg;
    logic [7:0]       opcode_next;
    logic [7:0]       modrm_reg;
    logic [7:0]       modrm_next;
    logic [15:0]      disp_reg;
    logic [15:0]      disp_next;
    logic [15:0]      imm_reg;
    logic [15:0]      imm_next;
    logic             emit;
    logic             no_imm;

    assign no_imm = (x86d_pkg::imm_len(opcode_reg) == x86d_pkg::LEN_NONE);

    always_comb
    begin
        phase_next = phase_reg;
        opcode_next = opcode_reg;
        modrm_next = modrm_reg;
        disp_next = disp_reg;
        imm_next = imm_reg;
        emit = 1'b0;
        case (phase_reg)
            x86d_pkg::PH_MODRM:
            begin
                modrm_next = code_byte;
                if (x86d_pkg::disp_len(code_byte) != x86d_pkg::LEN_NONE) begin
                    phase_next = x86d_pkg::PH_DISP_LO;
                end
                else if (no_imm) begin
                    emit = 1'b1;
                end
                else begin
                    phase_next = x86d_pkg::PH_IMM_LO;
                end
            end
            x86d_pkg::PH_DISP_LO:
            begin
                if (x86d_pkg::disp_len(modrm_reg) == x86d_pkg::LEN_BYTE) begin
                    disp_next = x86d_pkg::sext8(code_byte);
                    if (no_imm) emit = 1'b1;
                    else phase_next = x86d_pkg::PH_IMM_LO;
                end
                else begin
                    disp_next = {8'h00, code_byte};
                    phase_next = x86d_pkg::PH_DISP_HI;
                end
            end
            x86d_pkg::PH_DISP_HI:
            begin
                disp_next = {code_byte, disp_reg[7:0]};
                if (no_imm) emit = 1'b1;
                else phase_next = x86d_pkg::PH_IMM_LO;
            end
            x86d_pkg::PH_IMM_LO:
            begin
                if (x86d_pkg::imm_len(opcode_reg) == x86d_pkg::LEN_BYTE) begin
                    imm_next = x86d_pkg::sext8(code_byte);
                    emit = 1'b1;
                end
                else begin
                    imm_next = {8'h00, code_byte};
                    phase_next = x86d_pkg::PH_IMM_HI;
                end
            end
            x86d_pkg::PH_IMM_HI:
            begin
                imm_next = {code_byte, imm_reg[7:0]};
                emit = 1'b1;
            end
            x86d_pkg::PH_OFFSET:
            begin
                disp_next = x86d_pkg::sext8(code_byte);
                emit = 1'b1;
            end
            default:
            begin
                opcode_next = code_byte;
                modrm_next = 8'h00;
                disp_next = 16'h0000;
                imm_next = 16'h0000;
                case (x86d_pkg::form_of(code_byte))
                    x86d_pkg::FORM_ACC:  phase_next = x86d_pkg::PH_IMM_LO;
                    x86d_pkg::FORM_JUMP: phase_next = x86d_pkg::PH_OFFSET;
                    default:             phase_next = x86d_pkg::PH_MODRM;
                endcase
            end
        endcase
        if (emit) begin
            phase_next = x86d_pkg::PH_OPCODE;
        end
    end

    assign res.valid = take && emit;
    assign res.rec = x86d_pkg::build_record(opcode_next, modrm_next, disp_next, imm_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= x86d_pkg::PH_OPCODE;
            opcode_reg <= 8'h00;
            modrm_reg <= 8'h00;
            disp_reg <= 16'h0000;
            imm_reg <= 16'h0000;
        end
        else if (take) begin
            phase_reg <= phase_next;
            opcode_reg <= opcode_next;
            modrm_reg <= modrm_next;
            disp_reg <= disp_next;
            imm_reg <= imm_next;
        end
    end

endmodule

### rtl/x86d_outreg.sv
// Result register of the decoder: holds one decoded record until the
// receiver takes it. Depends on x86d_pkg.
module x86d_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  x86d_pkg::result_t res,
    input  logic              ready,
    output logic              valid,
    output x86d_pkg::record_t rec
);

    logic              valid_reg;
    logic              valid_next;
    x86d_pkg::record_t rec_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take) valid_next = res.valid;
        else if (ready) valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res.valid) begin
            rec_reg <= res.rec;
        end
    end

    assign valid = valid_reg;
    assign rec = rec_reg;

endmodule

### rtl/x86d_checker.sv
// Port-level checker for the decoder top level, attached by bind.
// Depends on assert_macros.svh and x86d_pkg.
`include "assert_macros.svh"

module x86d_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [55:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic jump_form;
    logic jump_rest_zero;
    logic in_seen;

    assign jump_form = (m_axis_tdata[1:0] == x86d_pkg::FORM_JUMP);
    assign jump_rest_zero = (m_axis_tdata[4:2] == 3'd0) && (m_axis_tdata[22:13] == 10'd0) &&
                            (m_axis_tdata[55:39] == 17'd0);
    assign in_seen = s_axis_tvalid && s_axis_tready;

    `X86D_ASSERT(a_hold_stalled, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "Stalled word changed.")
    `X86D_ASSERT(a_ready_rule, s_axis_tready == (!m_axis_tvalid || m_axis_tready), "Input ready does not follow the result register.")
    `X86D_ASSERT_RST(a_reset_idle, !rst_n |-> !m_axis_tvalid, "Result valid during reset.")
    `X86D_ASSERT(a_jump_fields, m_axis_tvalid && jump_form |-> jump_rest_zero, "Jump record carries operand fields.")
    `X86D_ASSERT(a_result_cause, $rose(m_axis_tvalid) |-> $past(in_seen), "Result without an accepted byte.")

endmodule

bind x86_16bit_add_sub_cmp_jump_decoder x86d_checker u_x86d_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
